/* design/usbcdp_pkg.sv */
package usbcdp_pkg;

  localparam int MAX_ENDPOINTS = 16;
  localparam int IDX_W = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
  localparam int CNT_W = $clog2(MAX_ENDPOINTS + 1);

  localparam logic [7:0] DESC_TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'd5;
  localparam logic [7:0] MIN_DESC_LEN        = 8'd2;
  localparam logic [7:0] MIN_IFACE_LEN       = 8'd9;
  localparam logic [7:0] MIN_EP_LEN          = 8'd7;

  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [7:0]  address;
    logic [1:0]  ep_type;
    logic [15:0] pkt_size;
    logic [7:0]  interval;
  } ep_entry_t;

  typedef struct packed {
    logic        interface_found;
    logic [7:0]  iface_class;
    logic [7:0]  iface_subclass;
    logic [7:0]  iface_protocol;
    logic [4:0]  endpoint_count;
    logic        match_found;
    logic [3:0]  match_index;
    logic [7:0]  ep_address;
    logic [15:0] ep_max_packet;
    logic [7:0]  ep_interval;
  } result_t;

endpackage

/* design/usbcdp_in_if.sv */
interface usbcdp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic       block_start;
  logic       block_end;
  logic [1:0] lookup_type;
  logic       lookup_dir_in;

  modport source (
    output valid, command, data_byte, block_start, block_end, lookup_type, lookup_dir_in,
    input  ready
  );
  modport sink (
    input  valid, command, data_byte, block_start, block_end, lookup_type, lookup_dir_in,
    output ready
  );
endinterface

/* design/usbcdp_out_if.sv */
interface usbcdp_out_if;
  logic        valid;
  logic        ready;
  logic        interface_found;
  logic [7:0]  iface_class;
  logic [7:0]  iface_subclass;
  logic [7:0]  iface_protocol;
  logic [4:0]  endpoint_count;
  logic        match_found;
  logic [3:0]  match_index;
  logic [7:0]  ep_address;
  logic [15:0] ep_max_packet;
  logic [7:0]  ep_interval;

  modport source (
    output valid, interface_found, iface_class, iface_subclass, iface_protocol,
           endpoint_count, match_found, match_index, ep_address, ep_max_packet, ep_interval,
    input  ready
  );
  modport sink (
    input  valid, interface_found, iface_class, iface_subclass, iface_protocol,
           endpoint_count, match_found, match_index, ep_address, ep_max_packet, ep_interval,
    output ready
  );
endinterface

/* design/usb_config_descriptor_parser.sv */
// USB configuration descriptor parser.
// item_i carries one beat per descriptor byte (command 0) or per endpoint
// lookup (command 1); result_o carries summary and lookup results.
// A plain descriptor byte is taken while the block stays in S_IDLE, so
// plain bytes can be taken back to back. A byte that completes an endpoint
// descriptor while the table is not empty starts a scan of the endpoint
// table for a duplicate address, one entry per cycle through a single
// address comparator; into an empty table the first entry is written
// without a scan. A lookup uses the same entry-per-cycle scan, stopping at
// the first match, then the S_EMIT step loads the result register. A
// block_end byte also passes through that load step after its own work.
// item_i.ready is low while a scan or a result load is in progress.
// Results sit in an output register; the block keeps taking bytes while
// one waits, and only holds in its load step if a new result is due while
// the receiver still stalls the previous one.
// Reset clears the entry count and flags at once (no clearing pass; the
// table storage is not reset) and parsing starts as if a block had begun.
module usb_config_descriptor_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  usbcdp_in_if.sink          item_i,
  usbcdp_out_if.source       result_o
);
  import usbcdp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DUP, S_LOOK, S_EMIT} state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic             seen_q, seen_d;
  logic [23:0]      codes_q, codes_d;
  logic [7:0]       off_q, off_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       kind_q, kind_d;
  logic [47:0]      fields_q, fields_d;
  logic             stopped_q, stopped_d;
  logic             end_q, end_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  ep_entry_t        cand_q, cand_d;
  logic [1:0]       want_type_q, want_type_d;
  logic             want_dir_q, want_dir_d;
  logic             mfound_q, mfound_d;
  logic [IDX_W-1:0] midx_q, midx_d;
  ep_entry_t        mentry_q, mentry_d;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  ep_entry_t        tbl_q [MAX_ENDPOINTS];
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  ep_entry_t        tbl_wdata;
  ep_entry_t        rd;
  logic             last;
  logic [31:0]      used_w;
  logic [31:0]      midx_w;

  assign rd     = tbl_q[scan_q];
  assign last   = (CNT_W'(scan_q) + CNT_W'(1)) == used_q;
  assign used_w = 32'(used_q);
  assign midx_w = 32'(midx_q);

  assign item_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    seen_d      = seen_q;
    codes_d     = codes_q;
    off_d       = off_q;
    len_d       = len_q;
    kind_d      = kind_q;
    fields_d    = fields_q;
    stopped_d   = stopped_q;
    end_d       = end_q;
    scan_d      = scan_q;
    cand_d      = cand_q;
    want_type_d = want_type_q;
    want_dir_d  = want_dir_q;
    mfound_d    = mfound_q;
    midx_d      = midx_q;
    mentry_d    = mentry_q;
    out_valid_d = out_valid_q && !result_o.ready;
    res_d       = res_q;
    tbl_we      = 1'b0;
    tbl_waddr   = '0;
    tbl_wdata   = cand_q;

    case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          scan_d = '0;
          mfound_d = 1'b0;
          midx_d = '0;
          mentry_d = '0;
          if (item_i.command == CMD_LOOKUP) begin
            want_type_d = item_i.lookup_type;
            want_dir_d  = item_i.lookup_dir_in;
            state_d     = S_LOOK;
          end else begin
            if (item_i.block_start) begin
              used_d    = '0;
              seen_d    = 1'b0;
              codes_d   = '0;
              off_d     = '0;
              len_d     = '0;
              kind_d    = '0;
              fields_d  = '0;
              stopped_d = 1'b0;
            end
            if (!stopped_d) begin
              if (off_d == 8'd0) begin
                if (item_i.data_byte < MIN_DESC_LEN) begin
                  stopped_d = 1'b1;
                end else begin
                  len_d    = item_i.data_byte;
                  kind_d   = '0;
                  fields_d = '0;
                  off_d    = 8'd1;
                end
              end else begin
                if (off_d == 8'd1) begin
                  kind_d = item_i.data_byte;
                end
                for (int k = 0; k < 6; k++) begin
                  if (off_d == 8'(k + 2)) begin
                    fields_d[8*k +: 8] = item_i.data_byte;
                  end
                end
                if (({1'b0, off_d} + 9'd1) == {1'b0, len_d}) begin
                  off_d = '0;
                  if (kind_d == DESC_TYPE_INTERFACE && len_d >= MIN_IFACE_LEN && !seen_d) begin
                    codes_d = {fields_d[31:24], fields_d[39:32], fields_d[47:40]};
                    seen_d  = 1'b1;
                  end
                  if (kind_d == DESC_TYPE_ENDPOINT && len_d >= MIN_EP_LEN &&
                      used_d < CNT_W'(MAX_ENDPOINTS)) begin
                    cand_d.address  = fields_d[7:0];
                    cand_d.ep_type  = fields_d[9:8];
                    cand_d.pkt_size = fields_d[31:16];
                    cand_d.interval = fields_d[39:32];
                    if (used_d == '0) begin
                      tbl_we    = 1'b1;
                      tbl_waddr = '0;
                      tbl_wdata = cand_d;
                      used_d    = CNT_W'(1);
                    end else begin
                      state_d = S_DUP;
                    end
                  end
                end else begin
                  off_d = off_d + 8'd1;
                end
              end
            end
            end_d = item_i.block_end;
            if (item_i.block_end) begin
              stopped_d = 1'b1;
              off_d     = '0;
              if (state_d == S_IDLE) begin
                state_d = S_EMIT;
              end
            end
          end
        end
      end

      S_DUP: begin
        if (rd.address == cand_q.address) begin
          state_d = end_q ? S_EMIT : S_IDLE;
        end else if (last) begin
          tbl_we    = 1'b1;
          tbl_waddr = used_q[IDX_W-1:0];
          used_d    = used_q + CNT_W'(1);
          state_d   = end_q ? S_EMIT : S_IDLE;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end

      S_LOOK: begin
        if (used_q == '0) begin
          state_d = S_EMIT;
        end else if (rd.address[7] == want_dir_q && rd.ep_type == want_type_q) begin
          mfound_d = 1'b1;
          midx_d   = scan_q;
          mentry_d = rd;
          state_d  = S_EMIT;
        end else if (last) begin
          state_d = S_EMIT;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end

      S_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          res_d.interface_found = seen_q;
          res_d.iface_class     = codes_q[23:16];
          res_d.iface_subclass  = codes_q[15:8];
          res_d.iface_protocol  = codes_q[7:0];
          res_d.endpoint_count  = used_w[4:0];
          res_d.match_found     = mfound_q;
          res_d.match_index     = midx_w[3:0];
          res_d.ep_address      = mentry_q.address;
          res_d.ep_max_packet   = mentry_q.pkt_size;
          res_d.ep_interval     = mentry_q.interval;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      seen_q      <= 1'b0;
      codes_q     <= '0;
      off_q       <= '0;
      len_q       <= '0;
      kind_q      <= '0;
      fields_q    <= '0;
      stopped_q   <= 1'b0;
      end_q       <= 1'b0;
      scan_q      <= '0;
      cand_q      <= '0;
      want_type_q <= '0;
      want_dir_q  <= 1'b0;
      mfound_q    <= 1'b0;
      midx_q      <= '0;
      mentry_q    <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      seen_q      <= seen_d;
      codes_q     <= codes_d;
      off_q       <= off_d;
      len_q       <= len_d;
      kind_q      <= kind_d;
      fields_q    <= fields_d;
      stopped_q   <= stopped_d;
      end_q       <= end_d;
      scan_q      <= scan_d;
      cand_q      <= cand_d;
      want_type_q <= want_type_d;
      want_dir_q  <= want_dir_d;
      mfound_q    <= mfound_d;
      midx_q      <= midx_d;
      mentry_q    <= mentry_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[tbl_waddr] <= tbl_wdata;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.interface_found = res_q.interface_found;
  assign result_o.iface_class     = res_q.iface_class;
  assign result_o.iface_subclass  = res_q.iface_subclass;
  assign result_o.iface_protocol  = res_q.iface_protocol;
  assign result_o.endpoint_count  = res_q.endpoint_count;
  assign result_o.match_found     = res_q.match_found;
  assign result_o.match_index     = res_q.match_index;
  assign result_o.ep_address      = res_q.ep_address;
  assign result_o.ep_max_packet   = res_q.ep_max_packet;
  assign result_o.ep_interval     = res_q.ep_interval;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_ENDPOINTS))
    else $error("endpoint count beyond table depth");

  a_dup_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUP |-> (used_q != '0) && (CNT_W'(scan_q) < used_q))
    else $error("duplicate scan outside stored entries");

  a_lookup_enters_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready && item_i.command == CMD_LOOKUP |=> state_q == S_LOOK)
    else $error("lookup beat did not start a table scan");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && (!out_valid_q || result_o.ready) |=> out_valid_q)
    else $error("result load did not raise valid");

endmodule

/* dv/usbcdp_parse_checker.sv */
`timescale 1ns / 1ps

module usbcdp_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  usbcdp_in_if        item_i,
  usbcdp_out_if       result_i,
  output int unsigned mismatch_count_o,
  output int unsigned open_results_o
);
  import usbcdp_pkg::*;

  ep_entry_t   ep_table [MAX_ENDPOINTS];
  int unsigned ep_used;
  logic        iface_seen;
  logic [23:0] iface_codes;
  int unsigned desc_offset;
  int unsigned desc_length;
  logic [7:0]  desc_kind;
  logic [47:0] desc_fields;
  logic        parse_stopped;
  result_t     expected_results [$];
  int unsigned mismatches;

  function automatic void clear_block();
    ep_used       = 0;
    iface_seen    = 1'b0;
    iface_codes   = '0;
    desc_offset   = 0;
    desc_length   = 0;
    desc_kind     = '0;
    desc_fields   = '0;
    parse_stopped = 1'b0;
  endfunction

  function automatic void reset_model();
    int k;
    for (k = 0; k < MAX_ENDPOINTS; k++) begin
      ep_table[k] = '0;
    end
    clear_block();
  endfunction

  function automatic void commit_descriptor();
    int unsigned k;
    bit          dup;
    if (desc_kind == DESC_TYPE_INTERFACE && desc_length >= MIN_IFACE_LEN && !iface_seen) begin
      iface_codes = {desc_fields[31:24], desc_fields[39:32], desc_fields[47:40]};
      iface_seen  = 1'b1;
    end
    if (desc_kind == DESC_TYPE_ENDPOINT && desc_length >= MIN_EP_LEN &&
        ep_used < MAX_ENDPOINTS) begin
      dup = 1'b0;
      for (k = 0; k < ep_used; k++) begin
        if (ep_table[k].address == desc_fields[7:0]) dup = 1'b1;
      end
      if (!dup) begin
        ep_table[ep_used] = '{address:  desc_fields[7:0],
                              ep_type:  desc_fields[9:8],
                              pkt_size: desc_fields[31:16],
                              interval: desc_fields[39:32]};
        ep_used++;
      end
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    if (desc_offset == 0) begin
      if (b < MIN_DESC_LEN) begin
        parse_stopped = 1'b1;
      end else begin
        desc_length = b;
        desc_kind   = '0;
        desc_fields = '0;
        desc_offset = 1;
      end
    end else begin
      if (desc_offset == 1) begin
        desc_kind = b;
      end else if (desc_offset <= 7) begin
        desc_fields[8*(desc_offset-2) +: 8] = b;
      end
      if (desc_offset + 1 == desc_length) begin
        commit_descriptor();
        desc_offset = 0;
      end else begin
        desc_offset = (desc_offset + 1) & 8'hFF;
      end
    end
  endfunction

  function automatic result_t block_summary();
    result_t r;
    r                 = '0;
    r.interface_found = iface_seen;
    r.iface_class     = iface_codes[23:16];
    r.iface_subclass  = iface_codes[15:8];
    r.iface_protocol  = iface_codes[7:0];
    r.endpoint_count  = 5'(ep_used);
    return r;
  endfunction

  function automatic void parse_beat(input logic cmd, input logic [7:0] b, input logic start,
                                     input logic last, input logic [1:0] want_type,
                                     input logic want_in, output bit has_result,
                                     output result_t res);
    int unsigned k;
    bit          hit;
    has_result = 1'b0;
    res        = block_summary();
    if (cmd == CMD_LOOKUP) begin
      hit = 1'b0;
      for (k = 0; k < ep_used; k++) begin
        if (!hit && ep_table[k].address[7] == want_in && ep_table[k].ep_type == want_type) begin
          hit               = 1'b1;
          res.match_found   = 1'b1;
          res.match_index   = 4'(k);
          res.ep_address    = ep_table[k].address;
          res.ep_max_packet = ep_table[k].pkt_size;
          res.ep_interval   = ep_table[k].interval;
        end
      end
      has_result = 1'b1;
    end else begin
      if (start) clear_block();
      if (!parse_stopped) take_byte(b);
      if (last) begin
        parse_stopped = 1'b1;
        desc_offset   = 0;
        has_result    = 1'b1;
        res           = block_summary();
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_result(input result_t got, input result_t want);
    if (got.interface_found !== want.interface_found)
      report_mismatch($sformatf("interface_found %0h, want %0h",
                                got.interface_found, want.interface_found));
    if (got.iface_class !== want.iface_class)
      report_mismatch($sformatf("iface_class %0h, want %0h", got.iface_class, want.iface_class));
    if (got.iface_subclass !== want.iface_subclass)
      report_mismatch($sformatf("iface_subclass %0h, want %0h",
                                got.iface_subclass, want.iface_subclass));
    if (got.iface_protocol !== want.iface_protocol)
      report_mismatch($sformatf("iface_protocol %0h, want %0h",
                                got.iface_protocol, want.iface_protocol));
    if (got.endpoint_count !== want.endpoint_count)
      report_mismatch($sformatf("endpoint_count %0d, want %0d",
                                got.endpoint_count, want.endpoint_count));
    if (got.match_found !== want.match_found)
      report_mismatch($sformatf("match_found %0h, want %0h", got.match_found, want.match_found));
    if (got.match_index !== want.match_index)
      report_mismatch($sformatf("match_index %0d, want %0d", got.match_index, want.match_index));
    if (got.ep_address !== want.ep_address)
      report_mismatch($sformatf("ep_address %0h, want %0h", got.ep_address, want.ep_address));
    if (got.ep_max_packet !== want.ep_max_packet)
      report_mismatch($sformatf("ep_max_packet %0h, want %0h",
                                got.ep_max_packet, want.ep_max_packet));
    if (got.ep_interval !== want.ep_interval)
      report_mismatch($sformatf("ep_interval %0h, want %0h", got.ep_interval, want.ep_interval));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    bit      has_result;
    result_t predicted;
    result_t observed;
    if (!rst_ni) begin
      reset_model();
      expected_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      open_results_o   <= 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        observed = '{interface_found: result_i.interface_found,
                     iface_class:     result_i.iface_class,
                     iface_subclass:  result_i.iface_subclass,
                     iface_protocol:  result_i.iface_protocol,
                     endpoint_count:  result_i.endpoint_count,
                     match_found:     result_i.match_found,
                     match_index:     result_i.match_index,
                     ep_address:      result_i.ep_address,
                     ep_max_packet:   result_i.ep_max_packet,
                     ep_interval:     result_i.ep_interval};
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          compare_result(observed, expected_results.pop_front());
        end
      end
      if (item_i.valid && item_i.ready) begin
        parse_beat(item_i.command, item_i.data_byte, item_i.block_start, item_i.block_end,
                   item_i.lookup_type, item_i.lookup_dir_in, has_result, predicted);
        if (has_result) expected_results.push_back(predicted);
      end
      mismatch_count_o <= mismatches;
      open_results_o   <= unsigned'(expected_results.size());
    end
  end

endmodule

/* dv/usb_config_descriptor_parser_test.sv */
`timescale 1ns / 1ps

module usb_config_descriptor_parser_test;
  import usbcdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned TARGET_ITEMS = 1300;
  localparam int unsigned SETTLE_CYCLES = 4 * MAX_ENDPOINTS;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned open_results;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;

  usbcdp_in_if  item_if ();
  usbcdp_out_if result_if ();

  usb_config_descriptor_parser i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  usbcdp_parse_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_if),
    .result_i         (result_if),
    .mismatch_count_o (mismatches),
    .open_results_o   (open_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= !(receiver_idles && $urandom_range(99) < 29);
    end
  end

  task automatic send_beat(input logic cmd, input logic [7:0] b, input logic start,
                           input logic last, input logic [1:0] want_type, input logic want_in);
    sender_idles   = !(items_sent >= 500 && items_sent < 700);
    receiver_idles = sender_idles;
    while (sender_idles && $urandom_range(99) < 29) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.command       <= cmd;
    item_if.data_byte     <= b;
    item_if.block_start   <= start;
    item_if.block_end     <= last;
    item_if.lookup_type   <= want_type;
    item_if.lookup_dir_in <= want_in;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start, input logic last);
    send_beat(CMD_BYTE, b, start, last, 2'($urandom), 1'($urandom));
  endtask

  task automatic send_lookup(input logic [1:0] want_type, input logic want_in);
    send_beat(CMD_LOOKUP, 8'($urandom), 1'($urandom), 1'($urandom), want_type, want_in);
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
  endtask

  task automatic send_random_block();
    logic [7:0]  block_bytes [$];
    logic [7:0]  addr_pool [$];
    logic [7:0]  addr;
    int unsigned n_desc;
    int unsigned ep_bias;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    int unsigned i;
    int unsigned j;
    block_bytes = {8'd9, 8'd2};
    repeat (7) block_bytes.push_back(8'($urandom));
    n_desc  = $urandom_range(1, 24);
    ep_bias = ($urandom_range(3) == 0) ? 90 : 45;
    for (i = 0; i < n_desc; i++) begin
      pick = $urandom_range(99);
      if (pick < ep_bias) begin
        if ($urandom_range(9) == 0) len = $urandom_range(2, 6);
        else if ($urandom_range(3) == 0) len = $urandom_range(8, 12);
        else len = 7;
        if (addr_pool.size() > 0 && $urandom_range(4) == 0) begin
          addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
        end else begin
          addr = 8'($urandom);
          addr_pool.push_back(addr);
        end
        block_bytes.push_back(8'(len));
        block_bytes.push_back(DESC_TYPE_ENDPOINT);
        if (len > 2) block_bytes.push_back(addr);
        for (j = 3; j < len; j++) block_bytes.push_back(8'($urandom));
      end else if (pick < ep_bias + 25) begin
        if ($urandom_range(7) == 0) len = $urandom_range(2, 8);
        else if ($urandom_range(3) == 0) len = $urandom_range(10, 14);
        else len = 9;
        block_bytes.push_back(8'(len));
        block_bytes.push_back(DESC_TYPE_INTERFACE);
        for (j = 2; j < len; j++) block_bytes.push_back(8'($urandom));
      end else if (pick < 97) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(100, 255) : $urandom_range(2, 16);
        block_bytes.push_back(8'(len));
        for (j = 1; j < len; j++) block_bytes.push_back(8'($urandom));
      end else begin
        block_bytes.push_back(8'($urandom_range(1)));
      end
    end
    if ($urandom_range(5) == 0) begin
      cut = $urandom_range(1, 3);
      while (cut > 0 && block_bytes.size() > 1) begin
        void'(block_bytes.pop_back());
        cut--;
      end
    end
    for (i = 0; i < block_bytes.size(); i++) begin
      if ($urandom_range(99) < 8) send_lookup(2'($urandom), 1'($urandom));
      send_byte(block_bytes[i], i == 0, i == block_bytes.size() - 1);
    end
    repeat ($urandom_range(2, 8)) send_lookup(2'($urandom), 1'($urandom));
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, $urandom_range(4) == 0);
    end
  endtask

  initial begin
    item_if.valid         = 1'b0;
    item_if.command       = CMD_BYTE;
    item_if.data_byte     = '0;
    item_if.block_start   = 1'b0;
    item_if.block_end     = 1'b0;
    item_if.lookup_type   = '0;
    item_if.lookup_dir_in = 1'b0;
    rst_ni                = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(CMD_LOOKUP, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0);
    // parse from reset without a block start
    send_byte(8'd7, 1'b0, 1'b0);
    send_byte(DESC_TYPE_ENDPOINT, 1'b0, 1'b0);
    send_byte(8'h81, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_beat(CMD_LOOKUP, 8'hFF, 1'b1, 1'b1, 2'd3, 1'b1);
    // short length, then bytes after the end
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'd9, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    // interface, then a truncated descriptor at the end
    send_byte(8'd9, 1'b1, 1'b0);
    send_byte(DESC_TYPE_INTERFACE, 1'b0, 1'b0);
    repeat (7) send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'd7, 1'b0, 1'b1);
    send_beat(CMD_LOOKUP, 8'h00, 1'b0, 1'b0, 2'd3, 1'b1);
    send_beat(CMD_LOOKUP, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0);
    drain_results();

    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(99) < 5) begin
        repeat ($urandom_range(1, 5)) begin
          send_beat(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
                    1'($urandom));
        end
      end
      send_random_block();
      if ($urandom_range(7) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && open_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
